### hw/rtl/ordered_list_table_engine_unit_defines.svh
// Assertion macros shared by the list engine RTL.
// The macros expect a signal named clk in the using scope, and OLTE_ASSERT also one named rst_n.
`ifndef ORDERED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// Check a property on every edge outside reset.
`define OLTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define OLTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/olte_pkg.sv
package olte_pkg;

  // Request codes on in_operation
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_FIND      = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  // Result codes on out_status
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Kind of walk the sequencer runs over the entry memory
  typedef enum logic [1:0] {
    K_INS  = 2'd0,
    K_REM  = 2'd1,
    K_FIND = 2'd2,
    K_READ = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_FINAL = 2'd2,
    S_DONE  = 2'd3
  } state_t;

endpackage

### hw/rtl/ordered_list_table_engine_unit.sv
// Ordered list engine: a bounded list of up to CAPACITY signed 32-bit values held in one
// single-port-read RAM, with a small sequencer that walks the RAM one entry per cycle. The
// block takes one request at a time; in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register without stopping the next request. Inserts
// write the new value after the shift, and a find that hits ends the walk at the match. Insert
// and remove at position p read count - p entries, find reads up to the first match and read
// reads one. An insert at the back or a find on an empty list reads nothing, and a rejected
// request skips the walk. While the previous result still waits in the output register, the
// block holds its own finished result until that one is taken. The walk length is set by the
// one RAM read port, which moves one entry per cycle.
module ordered_list_table_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_data_value,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_result_value,
  output logic [5:0]         out_found_position,
  output logic [5:0]         out_entry_count
);

  import olte_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          qv_r, qv_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working payload
  kind_t         kind_r, kind_nxt;
  logic [AW-1:0] at_r, at_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] qa_r, qa_nxt;
  status_t       res_st_r, res_st_nxt;
  logic [31:0]   res_val_r, res_val_nxt;
  logic [AW-1:0] res_pos_r, res_pos_nxt;

  // Output payload
  logic [2:0]    ost_r, ost_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic [5:0]    opos_r, opos_nxt;
  logic [5:0]    ocnt_r, ocnt_nxt;

  // Memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // Decode helpers
  op_t           op_in;
  logic          accept, full, empty, out_free;
  logic [31:0]   pos_ext, tot_ext;
  logic [CW-1:0] at_c;
  logic          walk_hit, walk_end;
  logic [AW+5:0] pos_wide;
  logic [CW+5:0] cnt_wide;

  olte_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign op_in    = op_t'(in_operation);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (total_r >= CAP_C);
  assign empty    = (total_r == '0);
  assign pos_ext  = 32'(in_position);
  assign tot_ext  = 32'(total_r);
  assign out_free = !out_valid_r || out_ready;

  // Pick the position a request acts on
  always_comb begin
    case (op_in)
      OP_INS_FRONT, OP_REM_FRONT, OP_FIND: at_c = '0;
      OP_INS_BACK:                         at_c = total_r;
      OP_REM_BACK:                         at_c = total_r - 1'b1;
      default:                             at_c = CW'(in_position);
    endcase
  end

  // Walk events: a match on the word just read, or nothing left to read or drain
  assign walk_hit = (state_r == S_WALK) && qv_r && (kind_r == K_FIND) && (ram_rdata == val_r);
  assign walk_end = (state_r == S_WALK) && !qv_r && (n_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WALK;
          case (op_in)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if ((op_in == OP_INS_AT && pos_ext > tot_ext) || full) begin
                state_nxt = S_DONE;
              end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
              if (empty || (op_in == OP_REM_AT && pos_ext >= tot_ext)) begin
                state_nxt = S_DONE;
              end
            end
            OP_READ: begin
              if (pos_ext >= tot_ext) begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_WALK;
          endcase
        end
      end
      S_WALK: begin
        if (walk_hit) begin
          state_nxt = S_DONE;
        end else if (walk_end) begin
          state_nxt = (kind_r == K_INS) ? S_FINAL : S_DONE;
        end
      end
      S_FINAL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    total_nxt     = total_r;
    qv_nxt        = 1'b0;
    kind_nxt      = kind_r;
    at_nxt        = at_r;
    val_nxt       = val_r;
    rp_nxt        = rp_r;
    n_nxt         = n_r;
    qa_nxt        = qa_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    res_pos_nxt   = res_pos_r;
    ram_we        = 1'b0;
    ram_waddr     = qa_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ost_nxt       = ost_r;
    oval_nxt      = oval_r;
    opos_nxt      = opos_r;
    ocnt_nxt      = ocnt_r;

    case (state_r)
      // Decode the beat, settle rejections at once, set up the walk
      S_IDLE: begin
        if (accept) begin
          val_nxt     = in_data_value;
          at_nxt      = AW'(at_c);
          res_val_nxt = '0;
          res_pos_nxt = AW'(at_c);
          res_st_nxt  = ST_OK;
          case (op_in)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              kind_nxt = K_INS;
              rp_nxt   = AW'(total_r - 1'b1);
              n_nxt    = total_r - at_c;
              if (op_in == OP_INS_AT && pos_ext > tot_ext) begin
                res_st_nxt = ST_BADPOS;
              end else if (full) begin
                res_st_nxt = ST_FULL;
              end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
              kind_nxt = K_REM;
              rp_nxt   = AW'(at_c);
              n_nxt    = total_r - at_c;
              if (empty) begin
                res_st_nxt = ST_EMPTY;
              end else if (op_in == OP_REM_AT && pos_ext >= tot_ext) begin
                res_st_nxt = ST_BADPOS;
              end
            end
            OP_FIND: begin
              kind_nxt = K_FIND;
              rp_nxt   = '0;
              n_nxt    = total_r;
            end
            default: begin
              kind_nxt = K_READ;
              rp_nxt   = AW'(at_c);
              n_nxt    = CW'(1);
              if (pos_ext >= tot_ext) begin
                res_st_nxt = ST_BADPOS;
              end
            end
          endcase
          if (res_st_nxt != ST_OK) begin
            res_pos_nxt = '0;
          end
        end
      end

      // Issue one read per cycle and retire the word that came back
      S_WALK: begin
        if (n_r != '0) begin
          ram_re = 1'b1;
          rp_nxt = (kind_r == K_INS) ? rp_r - 1'b1 : rp_r + 1'b1;
          n_nxt  = n_r - 1'b1;
          qa_nxt = rp_r;
          qv_nxt = 1'b1;
        end
        if (qv_r) begin
          case (kind_r)
            K_INS: begin
              ram_we    = 1'b1;
              ram_waddr = qa_r + 1'b1;
            end
            K_REM: begin
              if (qa_r == at_r) begin
                res_val_nxt = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = qa_r - 1'b1;
              end
            end
            K_FIND: begin
              if (walk_hit) begin
                res_pos_nxt = qa_r;
                qv_nxt      = 1'b0;
                n_nxt       = '0;
              end
            end
            default: res_val_nxt = ram_rdata;
          endcase
        end
        if (walk_end) begin
          case (kind_r)
            K_REM:   total_nxt = total_r - 1'b1;
            K_FIND: begin
              res_st_nxt  = ST_NOTFOUND;
              res_pos_nxt = '0;
            end
            default: total_nxt = total_r;
          endcase
        end
      end

      // Drop the new value into the gap the shift opened
      S_FINAL: begin
        ram_we    = 1'b1;
        ram_waddr = at_r;
        ram_wdata = val_r;
        total_nxt = total_r + 1'b1;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = res_st_r;
          oval_nxt      = res_val_r;
          opos_nxt      = pos_wide[5:0];
          ocnt_nxt      = cnt_wide[5:0];
        end
      end

      default: out_valid_nxt = out_valid_r && !out_ready;
    endcase
  end

  assign pos_wide = {6'd0, res_pos_r};
  assign cnt_wide = {6'd0, total_r};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      qv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      qv_r        <= qv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    at_r      <= at_nxt;
    val_r     <= val_nxt;
    rp_r      <= rp_nxt;
    n_r       <= n_nxt;
    qa_r      <= qa_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_pos_r <= res_pos_nxt;
    ost_r     <= ost_nxt;
    oval_r    <= oval_nxt;
    opos_r    <= opos_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = ost_r;
  assign out_result_value   = oval_r;
  assign out_found_position = opos_r;
  assign out_entry_count    = ocnt_r;

`include "ordered_list_table_engine_unit_defines.svh"

  `OLTE_ASSERT(a_total_bounded, total_r <= CAP_C, "entry count above capacity")
  `OLTE_ASSERT(a_idle_keeps_total, (state_r == S_IDLE) |=> (total_r == $past(total_r)),
               "entry count moved on accept")
  `OLTE_ASSERT(a_write_in_walk, ram_we |-> (state_r == S_WALK || state_r == S_FINAL),
               "memory written outside a walk")
  `OLTE_ASSERT_ALWAYS(a_reset_clears, (!rst_n) |=> (!out_valid_r && state_r == S_IDLE),
                      "reset left a result pending")

endmodule

### hw/rtl/olte_ram.sv
module olte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
